[hw/rtl/lsqf_pkg.sv]
// Shared types, constants and helper functions for the load/store queue.
// Used by lsqf_store_cell, lsqf_load_cell and load_store_queue_forwarding.
`default_nettype none

package lsqf_pkg;

    localparam int LQ_DEPTH  = 32;
    localparam int SQ_DEPTH  = 32;
    localparam int MAX_BYTES = 8;

    localparam int LQ_IDX_W = $clog2(LQ_DEPTH);
    localparam int SQ_IDX_W = $clog2(SQ_DEPTH);
    localparam int LQ_CNT_W = $clog2(LQ_DEPTH + 1);
    localparam int SQ_CNT_W = $clog2(SQ_DEPTH + 1);
    localparam int N_STEPS  = (LQ_DEPTH > SQ_DEPTH) ? LQ_DEPTH : SQ_DEPTH;
    localparam int STEP_W   = $clog2(N_STEPS + 1);

    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_EXEC_ST = 2'd1;
    localparam logic [1:0] REQ_EXEC_LD = 2'd2;
    localparam logic [1:0] REQ_REMOVE  = 2'd3;

    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_FWD     = 3'd1;
    localparam logic [2:0] ST_PARTIAL = 3'd2;
    localparam logic [2:0] ST_MERGED  = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    localparam logic [2:0] CFG_UNIFIED_MODE  = 3'd0;
    localparam logic [2:0] CFG_UNIFIED_CAP   = 3'd1;
    localparam logic [2:0] CFG_LOAD_CAP      = 3'd2;
    localparam logic [2:0] CFG_STORE_CAP     = 3'd3;
    localparam logic [2:0] CFG_IDEAL_PARTIAL = 3'd4;
    localparam logic [2:0] CFG_LITTLE_ENDIAN = 3'd5;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        is_store;
        logic [31:0] age_tag;
        logic [63:0] address;
        logic [3:0]  access_size;
        logic [63:0] store_data;
        logic [63:0] memory_data;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] load_value;
        logic        order_violation;
        logic [31:0] violating_age;
    } t_out;

    typedef struct packed {
        logic [31:0] age;
        logic [63:0] addr;
        logic [3:0]  size;
        logic        le;
    } t_bcast;

    typedef struct packed {
        logic [SQ_CNT_W-1:0]              cnt;
        logic                             free_v;
        logic [SQ_IDX_W-1:0]              free_idx;
        logic                             find_v;
        logic [SQ_IDX_W-1:0]              find_idx;
        logic                             prod_v;
        logic [31:0]                      prod_age;
        logic [63:0]                      prod_addr;
        logic [3:0]                       prod_bytes;
        logic [63:0]                      prod_value;
        logic [MAX_BYTES-1:0]             byte_v;
        logic [MAX_BYTES-1:0][31:0]       byte_age;
        logic [MAX_BYTES-1:0][7:0]        byte_val;
    } t_stok;

    typedef struct packed {
        logic [LQ_CNT_W-1:0] cnt;
        logic                free_v;
        logic [LQ_IDX_W-1:0] free_idx;
        logic                find_v;
        logic [LQ_IDX_W-1:0] find_idx;
        logic                viol_v;
        logic [31:0]         viol_age;
    } t_ltok;

    typedef struct packed {
        logic                alloc;
        logic                exec;
        logic                remove;
        logic [SQ_IDX_W-1:0] idx;
        logic [31:0]         age;
        logic [63:0]         addr;
        logic [3:0]          bytes;
        logic [63:0]         value;
    } t_swr;

    typedef struct packed {
        logic                alloc;
        logic                exec;
        logic                remove;
        logic [LQ_IDX_W-1:0] idx;
        logic [31:0]         age;
        logic [63:0]         addr;
        logic [3:0]          bytes;
    } t_lwr;

    function automatic logic [3:0] clamp_size(input logic [3:0] s);
        if (s == 4'd0) return 4'd1;
        if (s > 4'(MAX_BYTES)) return 4'(MAX_BYTES);
        return s;
    endfunction

    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        if (n >= 4'd8) return '1;
        return (64'd1 << {n[2:0], 3'b000}) - 64'd1;
    endfunction

    function automatic logic overlaps(input logic [63:0] a, input logic [3:0] n,
                                      input logic [63:0] b, input logic [3:0] m);
        logic [63:0] ba;
        logic [63:0] ab;
        ba = b - a;
        ab = a - b;
        return (ba < {60'd0, n}) || (ab < {60'd0, m});
    endfunction

    function automatic logic [5:0] byte_shift(input logic [2:0] off, input logic [3:0] n,
                                              input logic le);
        logic [3:0] rev;
        rev = n - 4'd1 - {1'b0, off};
        return le ? {off, 3'b000} : {rev[2:0], 3'b000};
    endfunction

endpackage

`default_nettype wire

[hw/rtl/lsqf_store_cell.sv]
// One store queue slot and its link in the store search chain.
// Depends on lsqf_pkg.
`default_nettype none

module lsqf_store_cell (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [lsqf_pkg::SQ_IDX_W-1:0]   i_idx,
    input  wire lsqf_pkg::t_bcast                i_bc,
    input  wire lsqf_pkg::t_stok                 i_tok,
    output lsqf_pkg::t_stok                      o_tok,
    input  wire lsqf_pkg::t_swr                  i_wr
);

    logic        r_valid, r_exec;
    logic [31:0] r_age;
    logic [63:0] r_addr;
    logic [3:0]  r_bytes;
    logic [63:0] r_value;
    lsqf_pkg::t_stok r_tok, n_tok;

    logic hit_old;
    logic mine;

    assign hit_old = r_valid && r_exec && (r_age <= i_bc.age);
    assign mine    = (i_wr.idx == i_idx);
    assign o_tok   = r_tok;

    always_comb begin
        logic [63:0] off;
        logic [63:0] ba;
        n_tok     = i_tok;
        n_tok.cnt = i_tok.cnt + lsqf_pkg::SQ_CNT_W'(r_valid);
        if (!r_valid && !i_tok.free_v) begin
            n_tok.free_v   = 1'b1;
            n_tok.free_idx = i_idx;
        end
        if (r_valid && (r_age == i_bc.age) && !i_tok.find_v) begin
            n_tok.find_v   = 1'b1;
            n_tok.find_idx = i_idx;
        end
        if (hit_old && lsqf_pkg::overlaps(i_bc.addr, i_bc.size, r_addr, r_bytes)
                && (!i_tok.prod_v || r_age > i_tok.prod_age)) begin
            n_tok.prod_v     = 1'b1;
            n_tok.prod_age   = r_age;
            n_tok.prod_addr  = r_addr;
            n_tok.prod_bytes = r_bytes;
            n_tok.prod_value = r_value;
        end
        for (int k = 0; k < lsqf_pkg::MAX_BYTES; k++) begin
            ba  = i_bc.addr + 64'(k);
            off = ba - r_addr;
            if ((4'(k) < i_bc.size) && hit_old && (off < {60'd0, r_bytes})
                    && (!i_tok.byte_v[k] || r_age > i_tok.byte_age[k])) begin
                n_tok.byte_v[k]   = 1'b1;
                n_tok.byte_age[k] = r_age;
                n_tok.byte_val[k] = 8'(r_value >> lsqf_pkg::byte_shift(off[2:0], r_bytes,
                                                                       i_bc.le));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_exec  <= 1'b0;
        end else if (mine) begin
            if (i_wr.alloc) begin
                r_valid <= 1'b1;
                r_exec  <= 1'b0;
                r_age   <= i_wr.age;
            end else if (i_wr.exec) begin
                r_exec  <= 1'b1;
                r_addr  <= i_wr.addr;
                r_bytes <= i_wr.bytes;
                r_value <= i_wr.value;
            end else if (i_wr.remove) begin
                r_valid <= 1'b0;
                r_exec  <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/lsqf_load_cell.sv]
// One load queue slot and its link in the load search chain.
// Depends on lsqf_pkg.
`default_nettype none

module lsqf_load_cell (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [lsqf_pkg::LQ_IDX_W-1:0]   i_idx,
    input  wire lsqf_pkg::t_bcast                i_bc,
    input  wire lsqf_pkg::t_ltok                 i_tok,
    output lsqf_pkg::t_ltok                      o_tok,
    input  wire lsqf_pkg::t_lwr                  i_wr
);

    logic        r_valid, r_exec;
    logic [31:0] r_age;
    logic [63:0] r_addr;
    logic [3:0]  r_bytes;
    lsqf_pkg::t_ltok r_tok, n_tok;

    logic mine;

    assign mine  = (i_wr.idx == i_idx);
    assign o_tok = r_tok;

    always_comb begin
        n_tok     = i_tok;
        n_tok.cnt = i_tok.cnt + lsqf_pkg::LQ_CNT_W'(r_valid);
        if (!r_valid && !i_tok.free_v) begin
            n_tok.free_v   = 1'b1;
            n_tok.free_idx = i_idx;
        end
        if (r_valid && (r_age == i_bc.age) && !i_tok.find_v) begin
            n_tok.find_v   = 1'b1;
            n_tok.find_idx = i_idx;
        end
        if (r_valid && r_exec && (r_age > i_bc.age)
                && lsqf_pkg::overlaps(i_bc.addr, i_bc.size, r_addr, r_bytes)
                && (!i_tok.viol_v || r_age < i_tok.viol_age)) begin
            n_tok.viol_v   = 1'b1;
            n_tok.viol_age = r_age;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_exec  <= 1'b0;
        end else if (mine) begin
            if (i_wr.alloc) begin
                r_valid <= 1'b1;
                r_exec  <= 1'b0;
                r_age   <= i_wr.age;
            end else if (i_wr.exec) begin
                r_exec  <= 1'b1;
                r_addr  <= i_wr.addr;
                r_bytes <= i_wr.bytes;
            end else if (i_wr.remove) begin
                r_valid <= 1'b0;
                r_exec  <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/load_store_queue_forwarding.sv]
// Top level of the load/store queue with store-to-load forwarding.
// Depends on lsqf_pkg, lsqf_store_cell and lsqf_load_cell.
//
//  channel   signals                                   direction
//  request   i_valid, o_stall, i_req                   in
//  response  o_valid, i_stall, o_rsp                   out
//  config    i_cfg_valid, o_cfg_ready, i_cfg_index,    in
//            i_cfg_data
//
// After a transaction is accepted, the search token walks one cell per cycle down the store
// and load chains, then the result is registered. The next request is accepted the cycle
// after the commit, so a new request is not taken until the previous one has committed.
// Synchronous active-low reset empties both queues. A stalled response holds the commit
// until the output register frees.
`default_nettype none

module load_store_queue_forwarding (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire lsqf_pkg::t_in  i_req,
    output logic                o_valid,
    input  wire logic           i_stall,
    output lsqf_pkg::t_out      o_rsp,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [2:0]     i_cfg_index,
    input  wire logic [6:0]     i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic [lsqf_pkg::STEP_W-1:0] r_cnt;
    lsqf_pkg::t_in  r_req;
    lsqf_pkg::t_out r_out, n_out;
    logic r_out_v;

    logic       r_unified, r_ideal, r_le;
    logic [6:0] r_ucap;
    logic [5:0] r_lcap, r_scap;

    lsqf_pkg::t_bcast bc;
    lsqf_pkg::t_stok  s_tok [lsqf_pkg::SQ_DEPTH+1];
    lsqf_pkg::t_ltok  l_tok [lsqf_pkg::LQ_DEPTH+1];
    lsqf_pkg::t_swr   swr;
    lsqf_pkg::t_lwr   lwr;

    logic accept, taken, last, done;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_v;
    assign o_rsp       = r_out;
    assign accept      = i_valid && !o_stall;
    assign taken       = r_out_v && !i_stall;
    assign last        = (r_state == S_RUN) && (r_cnt == lsqf_pkg::STEP_W'(lsqf_pkg::N_STEPS));
    assign done        = last && (!r_out_v || !i_stall);

    assign bc = {r_req.age_tag, r_req.address, lsqf_pkg::clamp_size(r_req.access_size), r_le};

    assign s_tok[0] = '0;
    assign l_tok[0] = '0;

    for (genvar c = 0; c < lsqf_pkg::SQ_DEPTH; c++) begin : g_sq
        lsqf_store_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (lsqf_pkg::SQ_IDX_W'(c)),
            .i_bc    (bc),
            .i_tok   (s_tok[c]),
            .o_tok   (s_tok[c+1]),
            .i_wr    (swr)
        );
    end

    for (genvar c = 0; c < lsqf_pkg::LQ_DEPTH; c++) begin : g_lq
        lsqf_load_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (lsqf_pkg::LQ_IDX_W'(c)),
            .i_bc    (bc),
            .i_tok   (l_tok[c]),
            .o_tok   (l_tok[c+1]),
            .i_wr    (lwr)
        );
    end

    always_comb begin
        lsqf_pkg::t_stok st;
        lsqf_pkg::t_ltok lt;
        logic        ok;
        logic [9:0]  nl, ns;
        logic [63:0] d;
        logic [3:0]  pb;
        logic [3:0]  rsh;
        logic [5:0]  sh;
        logic [63:0] merged;
        logic [5:0]  dsh;
        st  = s_tok[lsqf_pkg::SQ_DEPTH];
        lt  = l_tok[lsqf_pkg::LQ_DEPTH];
        nl  = 10'(lt.cnt);
        ns  = 10'(st.cnt);
        swr = '0;
        lwr = '0;
        swr.age   = r_req.age_tag;
        swr.addr  = r_req.address;
        swr.bytes = bc.size;
        swr.value = r_req.store_data & lsqf_pkg::byte_mask(bc.size);
        lwr.age   = r_req.age_tag;
        lwr.addr  = r_req.address;
        lwr.bytes = bc.size;
        n_out = '0;
        d   = r_req.address - st.prod_addr;
        pb  = st.prod_bytes;
        rsh = pb - {1'b0, d[2:0]} - bc.size;
        sh  = r_le ? {d[2:0], 3'b000} : {rsh[2:0], 3'b000};
        merged = r_req.memory_data & lsqf_pkg::byte_mask(bc.size);
        for (int k = 0; k < lsqf_pkg::MAX_BYTES; k++) begin
            dsh = lsqf_pkg::byte_shift(3'(k), bc.size, r_le);
            if (st.byte_v[k]) begin
                merged = (merged & ~(64'hff << dsh)) | ({56'd0, st.byte_val[k]} << dsh);
            end
        end
        if (r_unified) begin
            ok = (nl + ns + 10'd1) <= 10'(r_ucap);
        end else begin
            ok = (10'(r_lcap) >= nl + 10'(!r_req.is_store))
                 && (10'(r_scap) >= ns + 10'(r_req.is_store));
        end
        unique case (r_req.req_type)
            lsqf_pkg::REQ_ALLOC: begin
                if (ok && r_req.is_store && st.free_v) begin
                    swr.alloc = done;
                    swr.idx   = st.free_idx;
                end else if (ok && !r_req.is_store && lt.free_v) begin
                    lwr.alloc = done;
                    lwr.idx   = lt.free_idx;
                end else begin
                    n_out.status = lsqf_pkg::ST_FULL;
                end
            end
            lsqf_pkg::REQ_EXEC_ST: begin
                swr.exec = done && st.find_v;
                swr.idx  = st.find_idx;
                if (st.find_v && lt.viol_v) begin
                    n_out.order_violation = 1'b1;
                    n_out.violating_age   = lt.viol_age;
                end
            end
            lsqf_pkg::REQ_EXEC_LD: begin
                lwr.exec = done && lt.find_v;
                lwr.idx  = lt.find_idx;
                if (!st.prod_v) begin
                    n_out.load_value = r_req.memory_data & lsqf_pkg::byte_mask(bc.size);
                end else if ((d < {60'd0, pb}) && (bc.size <= pb)
                             && (d <= {60'd0, pb - bc.size})) begin
                    n_out.status     = lsqf_pkg::ST_FWD;
                    n_out.load_value = (st.prod_value >> sh) & lsqf_pkg::byte_mask(bc.size);
                end else if (!r_ideal) begin
                    n_out.status = lsqf_pkg::ST_PARTIAL;
                end else begin
                    n_out.status     = lsqf_pkg::ST_MERGED;
                    n_out.load_value = merged;
                end
            end
            lsqf_pkg::REQ_REMOVE: begin
                swr.remove = done && r_req.is_store && st.find_v;
                swr.idx    = st.find_idx;
                lwr.remove = done && !r_req.is_store && lt.find_v;
                lwr.idx    = lt.find_idx;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_RUN;
            S_RUN:   if (done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        if (done) begin
            r_out <= n_out;
        end
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_out_v   <= 1'b0;
            r_unified <= 1'b0;
            r_ucap    <= 7'd64;
            r_lcap    <= 6'd32;
            r_scap    <= 6'd32;
            r_ideal   <= 1'b0;
            r_le      <= 1'b1;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_cnt <= '0;
            end else if ((r_state == S_RUN) && !last) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (done) begin
                r_out_v <= 1'b1;
            end else if (taken) begin
                r_out_v <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    lsqf_pkg::CFG_UNIFIED_MODE:  r_unified <= i_cfg_data[0];
                    lsqf_pkg::CFG_UNIFIED_CAP:   r_ucap    <= i_cfg_data;
                    lsqf_pkg::CFG_LOAD_CAP:      r_lcap    <= i_cfg_data[5:0];
                    lsqf_pkg::CFG_STORE_CAP:     r_scap    <= i_cfg_data[5:0];
                    lsqf_pkg::CFG_IDEAL_PARTIAL: r_ideal   <= i_cfg_data[0];
                    lsqf_pkg::CFG_LITTLE_ENDIAN: r_le      <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire
